// ----- design/cec_pkg.sv -----
// Shared constants, register indexes and state type of the cascaded echo comb.
package cec_pkg;

   localparam int MAX_DELAY_FRAMES_DEFAULT = 2048;
   localparam int MAX_STAGES_DEFAULT       = 4;
   localparam int MAX_CHANNELS_DEFAULT     = 2;

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic signed [19:0] SAMPLE_MAX = 20'sd32767;
   localparam logic signed [19:0] SAMPLE_MIN = -20'sd32768;

   localparam logic [1:0]  CHANNEL_COUNT_RESET = 2'd1;
   localparam logic [11:0] BASE_DELAY_RESET    = 12'd0;
   localparam logic [2:0]  STAGE_COUNT_RESET   = 3'd1;
   localparam logic [15:0] GAIN_ONE_RESET      = 16'd16384;
   localparam logic [15:0] GAIN_TWO_RESET      = 16'd8192;
   localparam logic [15:0] GAIN_THREE_RESET    = 16'd4096;
   localparam logic [15:0] GAIN_FOUR_RESET     = 16'd2048;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT = 3'd0,
      CSR_BASE_DELAY    = 3'd1,
      CSR_STAGE_COUNT   = 3'd2,
      CSR_GAIN_ONE      = 3'd3,
      CSR_GAIN_TWO      = 3'd4,
      CSR_GAIN_THREE    = 3'd5,
      CSR_GAIN_FOUR     = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

endpackage

// ----- design/cec_store.sv -----
// Single-write, single-read delay sample memory with registered read data.
module cec_store
   import cec_pkg::*;
#(
   parameter int DEPTH  = 40960,
   parameter int ADDR_W = 16
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cascaded_echo_comb.sv -----
// Cascaded echo comb: up to MAX_STAGES feedforward comb stages on interleaved samples.
// Each sample runs the read, multiply and accumulate states of all MAX_STAGES stages,
// each a memory access, a multiply and a saturating add on the one shared datapath,
// then the done state; the next sample is accepted only after the result is output.
// Reset: a clearing pass writes zeros over the delay memory, one entry per cycle,
// MAX_CHANNELS*MAX_DELAY_FRAMES*MAX_STAGES*(MAX_STAGES+1)/2 slots (40960 by default).
module cascaded_echo_comb
   import cec_pkg::*;
#(
   parameter int MAX_DELAY_FRAMES = MAX_DELAY_FRAMES_DEFAULT,
   parameter int MAX_STAGES       = MAX_STAGES_DEFAULT,
   parameter int MAX_CHANNELS     = MAX_CHANNELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   localparam int SPAN   = MAX_CHANNELS * MAX_DELAY_FRAMES;
   localparam int DEPTH  = SPAN * MAX_STAGES * (MAX_STAGES + 1) / 2;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OFF_W  = $clog2(DEPTH + 1);
   localparam int LEN_W  = $clog2(MAX_STAGES * MAX_DELAY_FRAMES + 1);
   localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int ACT_W  = $clog2(MAX_STAGES + 1);
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);

   state_type state_ff, state_in;

   // Configuration registers.
   logic [1:0]        chan_count_ff;
   logic [11:0]       base_delay_ff;
   logic [2:0]        stage_count_ff;
   logic [GAIN_W-1:0] gain_ff [4];

   // Frame and channel positions.
   logic [LEN_W-1:0] pos_ff [MAX_STAGES];
   logic [CH_W-1:0]  chan_pos_ff;

   // Per-transaction datapath.
   logic signed [SAMPLE_W-1:0] x_ff;
   logic [STG_W-1:0]           stage_ff;
   logic [CH_W-1:0]            ch_ff;
   logic [CNT_W-1:0]           chans_ff;
   logic [ACT_W-1:0]           active_ff;
   logic [OFF_W-1:0]           offset_ff;
   logic [ADDR_W-1:0]          rd_addr_ff;
   logic [ADDR_W-1:0]          wr_addr_ff;
   logic                       dzero_ff;
   logic [17:0]                q_ff;
   logic                       neg_ff;
   logic [ADDR_W-1:0]          clr_ff;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   // Memory port.
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wa;
   logic [SAMPLE_W-1:0] mem_wd;
   logic [SAMPLE_W-1:0] mem_rd;

   logic accept, out_load, last_stage;

   // Normalized configuration.
   logic [CNT_W-1:0] chans;
   logic [CH_W-1:0]  ch_eff;
   logic [ACT_W-1:0] active;
   logic [LEN_W-1:0] base_eff;

   // Address unit.
   logic [STG_W-1:0]  addr_stage;
   logic [CH_W-1:0]   addr_ch;
   logic [OFF_W-1:0]  addr_off;
   logic [LEN_W-1:0]  addr_pos;
   logic [LEN_W-1:0]  addr_len;
   logic [LEN_W-1:0]  addr_d;
   logic [LEN_W:0]    addr_rp;
   logic [ADDR_W-1:0] addr_rd;
   logic [ADDR_W-1:0] addr_wr;

   // Multiply and accumulate.
   logic signed [SAMPLE_W-1:0] operand;
   logic [SAMPLE_W:0]          mag;
   logic [GAIN_W-1:0]          gain_sel;
   logic [SAMPLE_W+GAIN_W:0]   product;
   logic signed [19:0]         term;
   logic signed [19:0]         sum;
   logic signed [SAMPLE_W-1:0] sum_sat;
   logic [2:0]                 stage3;

   assign accept     = (state_ff == ST_IDLE) && req_valid;
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign last_stage = (32'(stage_ff) == MAX_STAGES - 1);
   assign csr_ready  = 1'b1;

   always_comb begin
      if (chan_count_ff == 2'd0) begin
         chans = CNT_W'(1);
      end else if (32'(chan_count_ff) > MAX_CHANNELS) begin
         chans = CNT_W'(MAX_CHANNELS);
      end else begin
         chans = CNT_W'(chan_count_ff);
      end
      ch_eff   = (32'(chan_pos_ff) >= 32'(chans)) ? '0 : chan_pos_ff;
      active   = (32'(stage_count_ff) > MAX_STAGES) ? ACT_W'(MAX_STAGES)
                                                    : ACT_W'(stage_count_ff);
      base_eff = (32'(base_delay_ff) > MAX_DELAY_FRAMES) ? LEN_W'(MAX_DELAY_FRAMES)
                                                          : LEN_W'(base_delay_ff);
   end

   // Addresses for the first stage are formed at the input transaction, those of
   // each later stage while the previous stage accumulates.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         addr_stage = '0;
         addr_ch    = ch_eff;
         addr_off   = '0;
      end else begin
         addr_stage = last_stage ? stage_ff : stage_ff + STG_W'(1);
         addr_ch    = ch_ff;
         addr_off   = OFF_W'(32'(offset_ff) + (32'(stage_ff) + 1) * SPAN);
      end
      addr_pos = pos_ff[addr_stage];
      addr_len = LEN_W'((32'(addr_stage) + 1) * MAX_DELAY_FRAMES);
      addr_d   = LEN_W'((32'(addr_stage) + 1) * 32'(base_eff));
      if (addr_pos >= addr_d) begin
         addr_rp = {1'b0, addr_pos} - {1'b0, addr_d};
      end else begin
         addr_rp = {1'b0, addr_pos} + {1'b0, addr_len} - {1'b0, addr_d};
      end
      addr_rd = ADDR_W'(32'(addr_off) + 32'(addr_rp) * MAX_CHANNELS + 32'(addr_ch));
      addr_wr = ADDR_W'(32'(addr_off) + 32'(addr_pos) * MAX_CHANNELS + 32'(addr_ch));
   end

   always_comb begin
      stage3 = 3'(stage_ff);
      case (stage3)
         3'd0:    gain_sel = gain_ff[0];
         3'd1:    gain_sel = gain_ff[1];
         3'd2:    gain_sel = gain_ff[2];
         3'd3:    gain_sel = gain_ff[3];
         default: gain_sel = '0;
      endcase
      operand = dzero_ff ? x_ff : $signed(mem_rd);
      mag     = operand[SAMPLE_W-1] ? (SAMPLE_W+1)'(-{operand[SAMPLE_W-1], operand})
                                    : {1'b0, operand};
      product = (SAMPLE_W+GAIN_W+1)'(mag * gain_sel);
      term    = neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
      sum     = 20'(x_ff) + term;
      if (sum > SAMPLE_MAX) begin
         sum_sat = SAMPLE_W'(SAMPLE_MAX);
      end else if (sum < SAMPLE_MIN) begin
         sum_sat = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         sum_sat = SAMPLE_W'(sum);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC: begin
            state_in = last_stage ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_wa    = wr_addr_ff;
      mem_wd    = x_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
         end
         ST_IDLE: req_stall = 1'b0;
         ST_READ: mem_we = 1'b1;
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   cec_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         chan_pos_ff    <= '0;
         for (int k = 0; k < MAX_STAGES; k++) begin
            pos_ff[k] <= '0;
         end
         chan_count_ff  <= CHANNEL_COUNT_RESET;
         base_delay_ff  <= BASE_DELAY_RESET;
         stage_count_ff <= STAGE_COUNT_RESET;
         gain_ff[0]     <= GAIN_ONE_RESET;
         gain_ff[1]     <= GAIN_TWO_RESET;
         gain_ff[2]     <= GAIN_THREE_RESET;
         gain_ff[3]     <= GAIN_FOUR_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // Frame positions move on after the last channel of a frame.
         if (out_load) begin
            if (32'(ch_ff) + 1 >= 32'(chans_ff)) begin
               chan_pos_ff <= '0;
               for (int k = 0; k < MAX_STAGES; k++) begin
                  if (32'(pos_ff[k]) + 1 >= (k + 1) * MAX_DELAY_FRAMES) begin
                     pos_ff[k] <= '0;
                  end else begin
                     pos_ff[k] <= pos_ff[k] + LEN_W'(1);
                  end
               end
            end else begin
               chan_pos_ff <= ch_ff + CH_W'(1);
            end
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_CHANNEL_COUNT: chan_count_ff  <= csr_data[1:0];
               CSR_BASE_DELAY:    base_delay_ff  <= csr_data[11:0];
               CSR_STAGE_COUNT:   stage_count_ff <= csr_data[2:0];
               CSR_GAIN_ONE:      gain_ff[0]     <= csr_data;
               CSR_GAIN_TWO:      gain_ff[1]     <= csr_data;
               CSR_GAIN_THREE:    gain_ff[2]     <= csr_data;
               CSR_GAIN_FOUR:     gain_ff[3]     <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff      <= req_sample_in;
         stage_ff  <= '0;
         ch_ff     <= ch_eff;
         chans_ff  <= chans;
         active_ff <= active;
      end
      if (accept || (state_ff == ST_ACC)) begin
         offset_ff  <= addr_off;
         rd_addr_ff <= addr_rd;
         wr_addr_ff <= addr_wr;
         dzero_ff   <= (addr_d == '0);
      end
      if (state_ff == ST_MUL) begin
         q_ff   <= product[SAMPLE_W+GAIN_W:15];
         neg_ff <= operand[SAMPLE_W-1];
      end
      if (state_ff == ST_ACC) begin
         if (32'(stage_ff) < 32'(active_ff)) begin
            x_ff <= sum_sat;
         end
         if (!last_stage) begin
            stage_ff <= stage_ff + STG_W'(1);
         end
      end
      if (out_load) begin
         rsp_data_ff <= x_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

// ----- tb/cascaded_echo_comb_tb.sv -----
// Self-checking testbench for the cascaded echo comb, with its own echo predictor.
`timescale 1ns / 1ps

module cascaded_echo_comb_tb;
   import cec_pkg::*;

   localparam int FRAMES      = MAX_DELAY_FRAMES_DEFAULT;
   localparam int STAGES      = MAX_STAGES_DEFAULT;
   localparam int CHANNELS    = MAX_CHANNELS_DEFAULT;
   localparam int HIST_DEPTH  = CHANNELS * FRAMES * STAGES * (STAGES + 1) / 2;
   localparam int DRAIN_CYCLES = 3 * STAGES + 8;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 3'd7;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   cascaded_echo_comb u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // Predictor copy of the register file and the echo history.
   logic [1:0]         chan_cfg   = CHANNEL_COUNT_RESET;
   logic [11:0]        delay_cfg  = BASE_DELAY_RESET;
   logic [2:0]         stages_cfg = STAGE_COUNT_RESET;
   logic [GAIN_W-1:0]  gain_cfg [STAGES];
   logic signed [15:0] echo_hist [HIST_DEPTH];
   int                 frame_pos [STAGES];
   int                 chan_pos = 0;

   logic signed [15:0] echo_expected [$];
   int mismatch_count = 0;
   int sample_total = 0;
   int setting_total = 0;
   int cycle_count = 0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_len = 0;
   int hold_go = 0;
   int hold_seen = 0;
   int hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [15:0] predict_echo(input logic signed [15:0] s);
      int chans, active, base, ch, len, d, pos, rp, offset, k;
      longint x, delayed, mag, q;
      chans = chan_cfg;
      if (chans == 0) chans = 1;
      if (chans > CHANNELS) chans = CHANNELS;
      active = stages_cfg;
      if (active > STAGES) active = STAGES;
      base = delay_cfg;
      if (base > FRAMES) base = FRAMES;
      if (chan_pos >= chans) chan_pos = 0;
      ch = chan_pos;
      x = s;
      offset = 0;
      for (k = 0; k < STAGES; k++) begin
         len = (k + 1) * FRAMES;
         d = (k + 1) * base;
         pos = frame_pos[k];
         if (pos >= len) pos = 0;
         if (d == 0) begin
            delayed = x;
         end else begin
            rp = (pos >= d) ? pos - d : pos + len - d;
            delayed = echo_hist[offset + rp * CHANNELS + ch];
         end
         echo_hist[offset + pos * CHANNELS + ch] = x[15:0];
         if (k < active) begin
            mag = (delayed < 0 ? -delayed : delayed) * longint'(gain_cfg[k]);
            q = mag >>> 15;
            if (delayed < 0) q = -q;
            x = x + q;
            if (x > SAMPLE_MAX) x = SAMPLE_MAX;
            if (x < SAMPLE_MIN) x = SAMPLE_MIN;
         end
         offset += len * CHANNELS;
      end
      // The frame positions move only once the last channel of a frame has gone by.
      if (ch + 1 >= chans) begin
         chan_pos = 0;
         for (k = 0; k < STAGES; k++)
            frame_pos[k] = (frame_pos[k] + 1 >= (k + 1) * FRAMES) ? 0 : frame_pos[k] + 1;
      end else begin
         chan_pos = ch + 1;
      end
      return x[15:0];
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_CHANNEL_COUNT: chan_cfg = data[1:0];
         CSR_BASE_DELAY:    delay_cfg = data[11:0];
         CSR_STAGE_COUNT:   stages_cfg = data[2:0];
         CSR_GAIN_ONE:      gain_cfg[0] = data;
         CSR_GAIN_TWO:      gain_cfg[1] = data;
         CSR_GAIN_THREE:    gain_cfg[2] = data;
         CSR_GAIN_FOUR:     gain_cfg[3] = data;
         default: ;
      endcase
   endfunction

   function automatic logic signed [15:0] draw_sample();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 19))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return r[15:0];
      endcase
   endfunction

   function automatic logic [15:0] draw_gain();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         default: return r[15:0];
      endcase
   endfunction

   function automatic logic [11:0] draw_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 12'd0;
      if (r < 18) return 12'(FRAMES);
      if (r < 23) return 12'($urandom_range(FRAMES + 1, 4095));
      return 12'($urandom_range(1, 24));
   endfunction

   // Lowers the input valid and waits until every predicted sample has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (echo_expected.size() != 0) @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [15:0] s);
      int gap;
      req_valid <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (!(req_valid && !req_stall));
      echo_expected.push_back(predict_echo(s));
      sample_total++;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Writes all registers plus the unused index; narrow fields carry junk in the upper bits.
   task automatic program_echo(input logic [1:0] chans, input logic [11:0] delay,
                               input logic [2:0] stages, input logic [15:0] g1,
                               input logic [15:0] g2, input logic [15:0] g3,
                               input logic [15:0] g4);
      logic [CSR_INDEX_W-1:0] idx [8];
      logic [CSR_DATA_W-1:0]  val [8];
      logic [15:0]            junk;
      wait_for_results();
      junk = 16'($urandom);
      idx = '{CSR_CHANNEL_COUNT, CSR_BASE_DELAY, CSR_STAGE_COUNT, CSR_INDEX_UNUSED,
              CSR_GAIN_ONE, CSR_GAIN_TWO, CSR_GAIN_THREE, CSR_GAIN_FOUR};
      val = '{{junk[15:2], chans}, {junk[15:12], delay}, {junk[15:3], stages}, junk,
              g1, g2, g3, g4};
      for (int n = 0; n < 8; n++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[n];
         csr_data <= val[n];
         do @(posedge clock); while (!(csr_valid && csr_ready));
         apply_register(idx[n], val[n]);
      end
      csr_valid <= 1'b0;
      setting_total++;
   endtask

   task automatic program_random();
      program_echo(2'($urandom_range(0, 3)), draw_delay(), 3'($urandom_range(0, 7)),
                   draw_gain(), draw_gain(), draw_gain(), draw_gain());
   endtask

   task automatic test_reset_defaults();
      logic signed [15:0] picks [8];
      picks = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF, 16'sh5555,
                16'shAAAA, 16'sh4000};
      foreach (picks[n]) send_sample(picks[n]);
   endtask

   // An oversized delay saturates to the full store, whose slots are still clear.
   task automatic test_early_frames();
      logic signed [15:0] picks [5];
      picks = '{16'sh7FFF, 16'sh8000, 16'sh3039, 16'shFFFF, 16'sh0000};
      program_echo(2'd1, 12'hFFF, 3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      foreach (picks[n]) send_sample(picks[n]);
   endtask

   task automatic test_zero_delay();
      logic signed [15:0] picks [4];
      picks = '{16'sh7FFF, 16'sh8000, 16'shFFFD, 16'sh0064};
      program_echo(2'd1, 12'd0, 3'd7, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001);
      foreach (picks[n]) send_sample(picks[n]);
   endtask

   // Leaves a frame half done, then shrinks the channel count so the position restarts.
   task automatic test_channel_switch();
      program_echo(2'd2, 12'd1, 3'd2, 16'h4000, 16'hFFFF, 16'h0000, 16'h0000);
      repeat (3) send_sample(draw_sample());
      program_echo(2'd0, 12'd1, 3'd3, 16'h8000, 16'h2000, 16'hFFFF, 16'h0000);
      repeat (3) send_sample(draw_sample());
      program_echo(2'd3, 12'd2, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (2) send_sample(draw_sample());
   endtask

   task automatic run_traffic(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct <= recv_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 35 == 0) program_random();
         send_sample(draw_sample());
         if ($urandom_range(0, 49) == 0) wait_for_results();
      end
   endtask

   // The output is held off long enough that the block backs up into its input.
   task automatic test_output_hold();
      program_random();
      send_idle_pct = 0;
      stall_pct <= 0;
      hold_len <= 400;
      hold_go <= hold_go + 1;
      repeat (30) send_sample(draw_sample());
   endtask

   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (echo_expected.size() == 0) begin
            $display("%0t: result %0d arrived with nothing expected", $time, rsp_sample_out);
            mismatch_count++;
         end else begin
            want = echo_expected.pop_front();
            if (rsp_sample_out !== want) begin
               $display("%0t: sample_out expected %0d, got %0d", $time, want,
                        rsp_sample_out);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("cascaded_echo_comb: mismatch");
         $finish;
      end
   end

   initial begin
      gain_cfg = '{GAIN_ONE_RESET, GAIN_TWO_RESET, GAIN_THREE_RESET, GAIN_FOUR_RESET};
      foreach (echo_hist[n]) echo_hist[n] = '0;
      foreach (frame_pos[n]) frame_pos[n] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_early_frames();
      test_zero_delay();
      test_channel_switch();
      run_traffic(140, 0, 0);
      run_traffic(140, 67, 0);
      run_traffic(140, 0, 67);
      run_traffic(140, 9, 9);
      test_output_hold();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (echo_expected.size() != 0)
         $display("%0t: %0d expected results never arrived", $time, echo_expected.size());
      $display("Checked %0d samples across %0d register settings, including saturated",
               sample_total, setting_total);
      $display("delays, out-of-range counts, idle and stall phases and a long output hold.");
      if (mismatch_count == 0 && echo_expected.size() == 0) begin
         $display("cascaded_echo_comb: match");
      end else begin
         $display("cascaded_echo_comb: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/cec_pkg.sv
design/cec_store.sv
design/cascaded_echo_comb.sv
tb/cascaded_echo_comb_tb.sv
